// ===== hw/rtl/spk_pkg.sv =====
// Shared types and constants for the shelf rectangle packer.
`timescale 1ns / 1ps
package spk_pkg;

    // Fixed field and counter widths.
    localparam int unsigned SIZE_W = 13;
    localparam int unsigned PAD_W  = 8;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned POS_W  = 22;
    localparam int unsigned ADDR_W = 4;

    // Configuration register addresses (word index).
    localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_EDGE_PADDING = 2'd2;
    localparam logic [1:0] REG_ITEM_SPACING = 2'd3;

    typedef struct packed {
        logic [12:0] rect_width;
        logic [12:0] rect_height;
        logic [12:0] order_key;
        logic        final_item;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]  item_index;
        logic [11:0] pos_x;
        logic [18:0] pos_y;
        logic [12:0] chosen_width;
        logic [12:0] chosen_height;
        logic        fits;
        logic        overflowed;
        logic        last_result;
    } out_beat_t;

    typedef struct packed {
        logic [12:0] atlas_width;
        logic [12:0] atlas_height;
        logic [7:0]  edge_padding;
        logic [7:0]  item_spacing;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       rect_rd;
        logic       rect_from_order;
        logic [5:0] rect_addr;
        logic       latch_key;
        logic       cmp;
        logic       j_before_i;
        logic       order_we;
        logic [5:0] order_wdata;
        logic       order_rd;
        logic [5:0] order_addr;
        logic       size_init;
        logic       pass_start;
        logic       pass_step;
        logic       fit_latch;
        logic       grow;
        logic       emit;
        logic       last;
        logic       finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [6:0] count;
        logic       fit_now;
        logic       can_grow;
        logic       both_fixed;
        logic       out_free;
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_RDI,
        ST_SORT_LATI,
        ST_SORT_RDJ,
        ST_SORT_CMPJ,
        ST_SORT_WR,
        ST_TRY_INIT,
        ST_TRY_RDO,
        ST_TRY_RDR,
        ST_TRY_STEP,
        ST_TRY_EVAL,
        ST_EMIT_INIT,
        ST_EMIT_RDO,
        ST_EMIT_RDR,
        ST_EMIT_STEP
    } state_t;

endpackage

// ===== hw/rtl/spk_ctrl.sv =====
// Controller state machine: load, rank sort, trial packing passes and emission.
`timescale 1ns / 1ps
module spk_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_final,
    output logic            in_stall,
    input  spk_pkg::stat_t  stat,
    output spk_pkg::cmd_t   cmd
);
    import spk_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] i_reg, j_reg, k_reg;
    logic [6:0] last_pos;
    logic       i_last, j_last, k_last, accept;

    assign last_pos = stat.count - 7'd1;
    assign i_last   = ({1'b0, i_reg} == last_pos);
    assign j_last   = ({1'b0, j_reg} == last_pos);
    assign k_last   = ({1'b0, k_reg} == last_pos);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (accept && in_final) state_next = ST_SORT_RDI;
            ST_SORT_RDI:  state_next = ST_SORT_LATI;
            ST_SORT_LATI: state_next = ST_SORT_RDJ;
            ST_SORT_RDJ:  state_next = ST_SORT_CMPJ;
            ST_SORT_CMPJ: state_next = j_last ? ST_SORT_WR : ST_SORT_RDJ;
            ST_SORT_WR:   state_next = i_last ? ST_TRY_INIT : ST_SORT_RDI;
            ST_TRY_INIT:  state_next = ST_TRY_RDO;
            ST_TRY_RDO:   state_next = ST_TRY_RDR;
            ST_TRY_RDR:   state_next = ST_TRY_STEP;
            ST_TRY_STEP:  state_next = k_last ? ST_TRY_EVAL : ST_TRY_RDO;
            ST_TRY_EVAL:
            begin
                if (stat.fit_now || stat.both_fixed || !stat.can_grow)
                    state_next = ST_EMIT_INIT;
                else
                    state_next = ST_TRY_INIT;
            end
            ST_EMIT_INIT: state_next = ST_EMIT_RDO;
            ST_EMIT_RDO:  state_next = ST_EMIT_RDR;
            ST_EMIT_RDR:  state_next = ST_EMIT_STEP;
            ST_EMIT_STEP:
            begin
                if (stat.out_free)
                    state_next = k_last ? ST_IDLE : ST_EMIT_RDO;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd                 = '0;
        cmd.load            = accept;
        cmd.j_before_i      = (j_reg < i_reg);
        cmd.order_wdata     = i_reg;
        cmd.order_addr      = k_reg;
        cmd.last            = k_last;
        unique case (state_reg)
            ST_IDLE:      ;
            ST_SORT_RDI:
            begin
                cmd.rect_rd   = 1'b1;
                cmd.rect_addr = i_reg;
            end
            ST_SORT_LATI: cmd.latch_key = 1'b1;
            ST_SORT_RDJ:
            begin
                cmd.rect_rd   = 1'b1;
                cmd.rect_addr = j_reg;
            end
            ST_SORT_CMPJ: cmd.cmp = 1'b1;
            ST_SORT_WR:
            begin
                cmd.order_we  = 1'b1;
                cmd.size_init = 1'b1;
            end
            ST_TRY_INIT:  cmd.pass_start = 1'b1;
            ST_TRY_RDO:   cmd.order_rd = 1'b1;
            ST_TRY_RDR:
            begin
                cmd.rect_rd         = 1'b1;
                cmd.rect_from_order = 1'b1;
            end
            ST_TRY_STEP:  cmd.pass_step = 1'b1;
            ST_TRY_EVAL:
            begin
                cmd.fit_latch = 1'b1;
                cmd.grow      = !(stat.fit_now || stat.both_fixed || !stat.can_grow);
            end
            ST_EMIT_INIT: cmd.pass_start = 1'b1;
            ST_EMIT_RDO:  cmd.order_rd = 1'b1;
            ST_EMIT_RDR:
            begin
                cmd.rect_rd         = 1'b1;
                cmd.rect_from_order = 1'b1;
            end
            ST_EMIT_STEP:
            begin
                cmd.emit      = stat.out_free;
                cmd.pass_step = stat.out_free;
                cmd.finish    = stat.out_free && k_last;
            end
            default:      ;
        endcase
    end

    // State and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:      i_reg <= '0;
                ST_SORT_LATI: j_reg <= '0;
                ST_SORT_CMPJ: j_reg <= j_reg + 6'd1;
                ST_SORT_WR:   i_reg <= i_reg + 6'd1;
                ST_TRY_INIT:  k_reg <= '0;
                ST_TRY_STEP:  k_reg <= k_reg + 6'd1;
                ST_EMIT_INIT: k_reg <= '0;
                ST_EMIT_STEP: if (stat.out_free) k_reg <= k_reg + 6'd1;
                default:      ;
            endcase
        end
    end

    // The sort only starts on a non-empty set.
    a_sort_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT_RDI) |-> (stat.count != 7'd0))
        else $error("sort started with an empty set");

    // Input is taken only while idle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("beat loaded outside idle");

    // Finishing a set always returns to idle.
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("finish did not return to idle");

endmodule

// ===== hw/rtl/spk_datapath.sv =====
// Datapath: rectangle and order memories, rank counter, shelf placement and output register.
`timescale 1ns / 1ps
module spk_datapath #(
    parameter int unsigned MAX_ITEMS  = 64,
    parameter int unsigned START_SIZE = 128,
    parameter int unsigned MAX_SIZE   = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spk_pkg::cfg_t       cfg,
    input  spk_pkg::in_beat_t   in_data,
    input  spk_pkg::cmd_t       cmd,
    output spk_pkg::stat_t      stat,
    input  logic                out_stall,
    output logic                out_valid,
    output spk_pkg::out_beat_t  out_data
);
    import spk_pkg::*;

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam logic [CNT_W-1:0]  CAP   = CNT_W'(MAX_ITEMS);
    localparam logic [SIZE_W-1:0] START = SIZE_W'(START_SIZE);
    localparam logic [SIZE_W-1:0] LIMIT = SIZE_W'(MAX_SIZE);

    logic [38:0] rect_mem [MAX_ITEMS];
    logic [5:0]  order_mem [MAX_ITEMS];
    logic [38:0] rect_rdata_reg;
    logic [5:0]  order_rdata_reg;

    logic [CNT_W-1:0]  item_count_reg;
    logic              drop_flag_reg;
    logic [12:0]       key_i_reg;
    logic [5:0]        rank_reg;
    logic [SIZE_W-1:0] w_reg, h_reg;
    logic signed [POS_W-1:0] x_reg, y_reg, row_reg;
    logic              fit_reg;
    logic              out_valid_reg;
    out_beat_t         out_data_reg;

    logic [5:0]  rect_raddr;
    logic [12:0] key_j;
    logic        aw_fixed, ah_fixed, grow_w, grow_h;
    logic signed [POS_W-1:0] pad_s, sp_s, iw_s, ih_s, right_s, bottom_s;
    logic signed [POS_W-1:0] x_place, y_place, row_base;
    logic        wrap;

    function automatic logic [SIZE_W-1:0] grow_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W:0] d;
        d = {v, 1'b0};
        return (d > {1'b0, LIMIT}) ? LIMIT : d[SIZE_W-1:0];
    endfunction

    // Memories: one write and one registered read each.
    assign rect_raddr = cmd.rect_from_order ? order_rdata_reg : cmd.rect_addr;
    always_ff @(posedge clk)
    begin
        if (cmd.load && (item_count_reg < CAP))
            rect_mem[item_count_reg[AW-1:0]] <=
                {in_data.order_key, in_data.rect_height, in_data.rect_width};
        if (cmd.rect_rd)
            rect_rdata_reg <= rect_mem[rect_raddr[AW-1:0]];
        if (cmd.order_we)
            order_mem[rank_reg[AW-1:0]] <= cmd.order_wdata;
        if (cmd.order_rd)
            order_rdata_reg <= order_mem[cmd.order_addr[AW-1:0]];
    end

    // Set occupancy and drop flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= '0;
            drop_flag_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            item_count_reg <= '0;
            drop_flag_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (item_count_reg < CAP)
                item_count_reg <= item_count_reg + 7'd1;
            else
                drop_flag_reg <= 1'b1;
        end
    end

    // Stable descending rank: larger keys, then equal keys loaded earlier.
    assign key_j = rect_rdata_reg[38:26];
    always_ff @(posedge clk)
    begin
        if (cmd.latch_key)
        begin
            key_i_reg <= key_j;
            rank_reg  <= '0;
        end
        else if (cmd.cmp)
        begin
            if ((key_j > key_i_reg) || ((key_j == key_i_reg) && cmd.j_before_i))
                rank_reg <= rank_reg + 6'd1;
        end
    end

    // Size search.
    assign aw_fixed = (cfg.atlas_width != '0);
    assign ah_fixed = (cfg.atlas_height != '0);
    always_comb
    begin
        grow_w = 1'b0;
        grow_h = 1'b0;
        priority if (aw_fixed)
            grow_h = (h_reg < LIMIT);
        else if (ah_fixed)
            grow_w = (w_reg < LIMIT);
        else
        begin
            grow_w = (w_reg < LIMIT) && (w_reg <= h_reg);
            grow_h = !grow_w && (h_reg < LIMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.size_init)
        begin
            w_reg <= aw_fixed ? cfg.atlas_width : START;
            h_reg <= ah_fixed ? cfg.atlas_height : START;
        end
        else if (cmd.grow)
        begin
            if (grow_w)
                w_reg <= grow_size(w_reg);
            if (grow_h)
                h_reg <= grow_size(h_reg);
        end
    end

    // Shelf placement of one rectangle.
    assign pad_s    = $signed({14'd0, cfg.edge_padding});
    assign sp_s     = $signed({14'd0, cfg.item_spacing});
    assign iw_s     = $signed({9'd0, rect_rdata_reg[12:0]});
    assign ih_s     = $signed({9'd0, rect_rdata_reg[25:13]});
    assign right_s  = $signed({9'd0, w_reg}) - 22'sd1 - pad_s;
    assign bottom_s = $signed({9'd0, h_reg}) - 22'sd1 - pad_s;
    assign wrap     = (x_reg + iw_s) > right_s;
    assign x_place  = wrap ? pad_s : x_reg;
    assign y_place  = wrap ? (y_reg + row_reg + sp_s) : y_reg;
    assign row_base = wrap ? '0 : row_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
        begin
            x_reg   <= pad_s;
            y_reg   <= pad_s;
            row_reg <= '0;
        end
        else if (cmd.pass_step)
        begin
            x_reg   <= x_place + iw_s + sp_s;
            y_reg   <= y_place;
            row_reg <= (ih_s > row_base) ? ih_s : row_base;
        end
        if (cmd.fit_latch)
            fit_reg <= stat.fit_now;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.item_index    <= order_rdata_reg;
            out_data_reg.pos_x         <= x_place[11:0];
            out_data_reg.pos_y         <= y_place[18:0];
            out_data_reg.chosen_width  <= w_reg;
            out_data_reg.chosen_height <= h_reg;
            out_data_reg.fits          <= fit_reg;
            out_data_reg.overflowed    <= drop_flag_reg;
            out_data_reg.last_result   <= cmd.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign stat.count      = item_count_reg;
    assign stat.fit_now    = (y_reg + row_reg) <= bottom_s;
    assign stat.can_grow   = grow_w || grow_h;
    assign stat.both_fixed = aw_fixed && ah_fixed;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= CAP)
        else $error("item count above capacity");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        drop_flag_reg |-> (item_count_reg == CAP))
        else $error("drop flag set with room left");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten before it was taken");

    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> ((item_count_reg == '0) && !drop_flag_reg))
        else $error("set state not cleared after finish");

endmodule

// ===== hw/rtl/shelf_rectangle_packer_unit.sv =====
// Input beats are taken one per cycle while idle; after the final beat the rank sort runs,
// then trial packing passes (up to about eleven passes in size search), then emission:
// each result reads the order memory, then the rectangle memory, and waits on output stalls.
// Input stalls from the final beat until the last result enters the output register.
// Reset clears control, counts, flags and config registers, not the memories or data registers.
// Top level of the shelf rectangle packer with its configuration registers.
`timescale 1ns / 1ps
module shelf_rectangle_packer_unit #(
    parameter int unsigned MAX_ITEMS  = 64,
    parameter int unsigned START_SIZE = 128,
    parameter int unsigned MAX_SIZE   = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  spk_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output spk_pkg::out_beat_t  out_data
);
    import spk_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  cfg_write;

    // Configuration register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ATLAS_WIDTH:  cfg_reg.atlas_width  <= pwdata[12:0];
                REG_ATLAS_HEIGHT: cfg_reg.atlas_height <= pwdata[12:0];
                REG_EDGE_PADDING: cfg_reg.edge_padding <= pwdata[7:0];
                REG_ITEM_SPACING: cfg_reg.item_spacing <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ATLAS_WIDTH:  prdata = {19'd0, cfg_reg.atlas_width};
            REG_ATLAS_HEIGHT: prdata = {19'd0, cfg_reg.atlas_height};
            REG_EDGE_PADDING: prdata = {24'd0, cfg_reg.edge_padding};
            REG_ITEM_SPACING: prdata = {24'd0, cfg_reg.item_spacing};
            default:          prdata = '0;
        endcase
    end

    spk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_final (in_data.final_item),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    spk_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .START_SIZE (START_SIZE),
        .MAX_SIZE   (MAX_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
